FILE: rtl/qbd_pkg.sv
`default_nettype none
package qbd_pkg;

  // block layout codes
  localparam logic [2:0] FMT_Q4_0 = 3'd0;
  localparam logic [2:0] FMT_Q8_0 = 3'd1;
  localparam logic [2:0] FMT_Q4_K = 3'd2;
  localparam logic [2:0] FMT_Q5_K = 3'd3;
  localparam logic [2:0] FMT_Q6_K = 3'd4;

  // configuration register indexes
  localparam logic REG_FORMAT  = 1'b0;
  localparam logic REG_ROW_LEN = 1'b1;

  localparam int LANES = 4;

  // bytes per block
  function automatic logic [7:0] fmt_bytes(input logic [2:0] fmt);
    logic [7:0] n;
    unique case (fmt)
      FMT_Q4_0: n = 8'd18;
      FMT_Q8_0: n = 8'd34;
      FMT_Q4_K: n = 8'd144;
      FMT_Q5_K: n = 8'd176;
      FMT_Q6_K: n = 8'd210;
      default:  n = 8'd0;
    endcase
    return n;
  endfunction

  // elements per block
  function automatic logic [8:0] fmt_elems(input logic [2:0] fmt);
    logic [8:0] n;
    unique case (fmt)
      FMT_Q4_0, FMT_Q8_0: n = 9'd32;
      default:            n = 9'd256;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/qbd_ram.sv
`default_nettype none
module qbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

FILE: rtl/quant_block_dequantizer.sv
`default_nettype none
// channel   | ports                                         | dir | handshake
// byte in   | start_i, data_byte_i, busy_o                  | in  | start_i & !busy_o
// config    | cfg_valid_i, cfg_index_i, cfg_data_i, cfg_ready_o | in | valid & ready
// result    | result_valid_o, value0..3_o, valid_count_o,   | out | strobe, one cycle
//           | block_last_o, row_last_o                      |     |
//
// bytes are taken one per cycle while busy_o is low; the block's last byte raises busy_o.
// decode: the half scales are fetched first, then per element five store reads through the
// single read port, two multiplies, align, normalize and round follow in that order; a result
// strobes after every fourth element or the block's last.
// reset clears format to Q4_0, row length to 256 and the counters; the store is not cleared.
// results cannot be stalled by the receiver.
module quant_block_dequantizer #(
  parameter int BLOCK_STORE_DEPTH = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [7:0]  data_byte_i,
  output      logic        busy_o,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [20:0] cfg_data_i,
  output      logic        result_valid_o,
  output      logic [31:0] value0_o,
  output      logic [31:0] value1_o,
  output      logic [31:0] value2_o,
  output      logic [31:0] value3_o,
  output      logic [2:0]  valid_count_o,
  output      logic        block_last_o,
  output      logic        row_last_o
);

  localparam int AW = $clog2(BLOCK_STORE_DEPTH);
  localparam int W  = 56;

  typedef enum logic [2:0] {
    S_IDLE, S_HDR, S_RD, S_MUL1, S_MUL2, S_ALN, S_NRM, S_RND
  } state_e;

  state_e       state_q;
  logic [2:0]   fmt_q;
  logic [20:0]  rl_q;
  logic [20:0]  done_q;
  logic [7:0]   bp_q;
  logic [8:0]   n_q;
  logic         row_end_q;
  logic [7:0]   e_q;
  logic [2:0]   rd_cnt_q;
  logic [7:0]   hdr_q [4];
  logic [7:0]   byte_q [5];
  logic [12:0]  f_mag_q;
  logic         f_sign_q;
  logic         zero_q;
  logic [5:0]   m_q;
  logic [23:0]  t1_q;
  logic [16:0]  t2_q;
  logic [W-1:0] mag_q;
  logic         sgn_q;
  logic signed [6:0] emin_q;
  logic [5:0]   sh_q;
  logic         nan_q;
  logic         inf_q;
  logic         isg_q;
  logic [31:0]  val_q [qbd_pkg::LANES];
  logic         res_valid_q;
  logic [2:0]   cnt_q;
  logic         blast_q;
  logic         rlast_q;

  // byte intake
  logic         accept, fmt_ok, wr_en, blk_done;
  logic [7:0]   nbytes, bp_eff;
  logic [AW-1:0] raddr;
  logic [7:0]   rdata, a8;

  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i & ~busy_o;
  assign fmt_ok      = (fmt_q <= qbd_pkg::FMT_Q6_K);
  assign nbytes      = qbd_pkg::fmt_bytes(fmt_q);
  assign bp_eff      = (bp_q >= nbytes) ? 8'd0 : bp_q;
  assign wr_en       = accept & fmt_ok;
  assign blk_done    = wr_en & (({1'b0, bp_eff} + 9'd1) == {1'b0, nbytes});

  qbd_ram #(.WIDTH(8), .DEPTH(BLOCK_STORE_DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AW'(bp_eff)),
    .wdata_i (data_byte_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // row bookkeeping at block completion
  logic [20:0] rl, done0, rem, done_sum, done_next;
  logic [8:0]  elems, nblk;
  logic        row_end;
  always_comb begin
    rl        = (rl_q == 21'd0) ? 21'd1 : rl_q;
    done0     = (done_q >= rl) ? 21'd0 : done_q;
    rem       = rl - done0;
    elems     = qbd_pkg::fmt_elems(fmt_q);
    row_end   = (rem <= 21'(elems));
    nblk      = row_end ? rem[8:0] : elems;
    done_sum  = done0 + 21'(nblk);
    done_next = (done_sum >= rl) ? 21'd0 : done_sum;
  end

  // element coordinates
  logic       is_k, is_q5, is_q6;
  logic [2:0] j;
  logic [4:0] l;
  logic [1:0] g;
  assign is_k  = (fmt_q == qbd_pkg::FMT_Q4_K) || (fmt_q == qbd_pkg::FMT_Q5_K);
  assign is_q5 = (fmt_q == qbd_pkg::FMT_Q5_K);
  assign is_q6 = (fmt_q == qbd_pkg::FMT_Q6_K);
  assign j     = e_q[7:5];
  assign l     = e_q[4:0];
  assign g     = e_q[6:5];

  // store read address
  always_comb begin
    a8 = 8'd0;
    if (state_q == S_HDR) begin
      unique case (rd_cnt_q)
        3'd0:    a8 = is_q6 ? 8'd208 : 8'd0;
        3'd1:    a8 = is_q6 ? 8'd209 : 8'd1;
        3'd2:    a8 = 8'd2;
        3'd3:    a8 = 8'd3;
        default: a8 = 8'd0;
      endcase
    end else if (state_q == S_RD) begin
      if (fmt_q == qbd_pkg::FMT_Q4_0) begin
        a8 = 8'd2 + {4'd0, e_q[4:1]};
      end else if (fmt_q == qbd_pkg::FMT_Q8_0) begin
        a8 = 8'd2 + {3'd0, e_q[4:0]};
      end else if (is_k) begin
        unique case (rd_cnt_q)
          3'd0:    a8 = {5'd0, j};
          3'd1:    a8 = 8'd4 + {5'd0, j};
          3'd2:    a8 = 8'd8 + {5'd0, j};
          3'd3:    a8 = (is_q5 ? 8'd48 : 8'd16) + {1'b0, j[2:1], l};
          default: a8 = 8'd16 + {3'd0, l};
        endcase
      end else begin
        unique case (rd_cnt_q)
          3'd0:    a8 = {1'b0, e_q[7], e_q[5], l};
          3'd1:    a8 = {2'b10, e_q[7], l};
          default: a8 = 8'd192 + {4'd0, e_q[7], 3'd0} + {5'd0, g, 1'b0} + {7'd0, l[4]};
        endcase
      end
    end
  end
  assign raddr = AW'(a8);

  // half scale decode
  logic        d_sign, dm_sign, dnan, dinf, dmnan, dminf;
  logic [4:0]  dex, dmex;
  logic [10:0] d_m, dm_m;
  logic signed [6:0] ed, em;
  always_comb begin
    d_sign  = hdr_q[1][7];
    dex     = hdr_q[1][6:2];
    d_m     = {(dex != 5'd0), hdr_q[1][1:0], hdr_q[0]};
    dnan    = (dex == 5'h1F) && (d_m[9:0] != 10'd0);
    dinf    = (dex == 5'h1F) && (d_m[9:0] == 10'd0);
    ed      = (dex == 5'd0) ? -7'sd24 : $signed({2'b00, dex}) - 7'sd25;
    dm_sign = hdr_q[3][7];
    dmex    = hdr_q[3][6:2];
    dm_m    = {(dmex != 5'd0), hdr_q[3][1:0], hdr_q[2]};
    dmnan   = (dmex == 5'h1F) && (dm_m[9:0] != 10'd0);
    dminf   = (dmex == 5'h1F) && (dm_m[9:0] == 10'd0);
    em      = (dmex == 5'd0) ? -7'sd24 : $signed({2'b00, dmex}) - 7'sd25;
  end

  // quant and scale unpacking
  logic signed [8:0]  a_s, b_s;
  logic signed [17:0] prod;
  logic [5:0] sc6, m6;
  logic [3:0] nib;
  logic [1:0] hb;
  logic       hbit;
  always_comb begin
    a_s  = 9'sd0;
    b_s  = 9'sd1;
    m6   = 6'd0;
    sc6  = 6'd0;
    nib  = 4'd0;
    hb   = 2'd0;
    hbit = 1'b0;
    if (fmt_q == qbd_pkg::FMT_Q4_0) begin
      nib = e_q[0] ? byte_q[0][7:4] : byte_q[0][3:0];
      a_s = $signed({5'd0, nib}) - 9'sd8;
    end else if (fmt_q == qbd_pkg::FMT_Q8_0) begin
      a_s = $signed({byte_q[0][7], byte_q[0]});
    end else if (is_k) begin
      if (!j[2]) begin
        sc6 = byte_q[1][5:0];
        m6  = byte_q[2][5:0];
      end else begin
        sc6 = {byte_q[0][7:6], byte_q[2][3:0]};
        m6  = {byte_q[1][7:6], byte_q[2][7:4]};
      end
      nib  = j[0] ? byte_q[3][7:4] : byte_q[3][3:0];
      hbit = is_q5 & byte_q[4][j];
      a_s  = $signed({3'd0, sc6});
      b_s  = $signed({4'd0, hbit, nib});
    end else begin
      nib = g[1] ? byte_q[0][7:4] : byte_q[0][3:0];
      unique case (g)
        2'd0: hb = byte_q[1][1:0];
        2'd1: hb = byte_q[1][3:2];
        2'd2: hb = byte_q[1][5:4];
        2'd3: hb = byte_q[1][7:6];
      endcase
      a_s = $signed({byte_q[2][7], byte_q[2]});
      b_s = $signed({3'd0, hb, nib}) - 9'sd32;
    end
    prod = a_s * b_s;
  end

  // alignment and signed sum
  logic signed [6:0]  emin;
  logic [4:0]         sh1, sh2;
  logic [W-1:0]       av, bv, amag;
  logic               s1, s2, rsgn;
  logic signed [W:0]  va, vb, r;
  logic [W:0]         rabs;
  logic               nan_a, nan_b, inf_a, inf_b, nan_n, inf_n, isg_n;
  always_comb begin
    emin = (is_k && (em < ed)) ? em : ed;
    sh1  = 5'(ed - emin);
    sh2  = 5'(em - emin);
    av   = W'(t1_q) << sh1;
    bv   = is_k ? (W'(t2_q) << sh2) : '0;
    s1   = is_k ? d_sign : (f_sign_q ^ d_sign);
    s2   = dm_sign;
    va   = s1 ? -$signed({1'b0, av}) : $signed({1'b0, av});
    vb   = s2 ? -$signed({1'b0, bv}) : $signed({1'b0, bv});
    r    = va - vb;
    rabs = r[W] ? (W+1)'(-r) : (W+1)'(r);
    amag = rabs[W-1:0];
    if (amag != '0) begin
      rsgn = r[W];
    end else if (is_k) begin
      rsgn = (av == '0) && (bv == '0) && s1 && !s2;
    end else begin
      rsgn = s1;
    end
    nan_a = dnan | (dinf & zero_q);
    inf_a = dinf & ~nan_a;
    nan_b = is_k & (dmnan | (dminf & (m_q == 6'd0)));
    inf_b = is_k & dminf & ~nan_b;
    nan_n = nan_a | nan_b | (inf_a & inf_b & (d_sign == dm_sign));
    inf_n = inf_a | inf_b;
    isg_n = inf_a ? s1 : ~s2;
  end

  // rounding to binary32
  logic signed [9:0] exp_v;
  logic        rnd;
  logic [30:0] body;
  logic [31:0] bits;
  always_comb begin
    exp_v = 10'sd182 - $signed({4'd0, sh_q}) + 10'(emin_q);
    rnd   = mag_q[31] & ((|mag_q[30:0]) | mag_q[32]);
    body  = {exp_v[7:0], mag_q[54:32]} + {30'd0, rnd};
    if (nan_q) begin
      bits = 32'h7FC0_0000;
    end else if (inf_q) begin
      bits = {isg_q, 31'h7F80_0000};
    end else if (mag_q == '0) begin
      bits = {sgn_q, 31'd0};
    end else begin
      bits = {sgn_q, body};
    end
  end

  logic last_el;
  assign last_el = (({1'b0, e_q} + 9'd1) == n_q);

  // sequencer, counters and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fmt_q       <= qbd_pkg::FMT_Q4_0;
      rl_q        <= 21'd256;
      done_q      <= 21'd0;
      bp_q        <= 8'd0;
      rd_cnt_q    <= 3'd0;
      e_q         <= 8'd0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == qbd_pkg::REG_FORMAT) begin
          fmt_q <= cfg_data_i[2:0];
          bp_q  <= 8'd0;
        end else begin
          rl_q <= cfg_data_i;
        end
        done_q <= 21'd0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (wr_en) begin
            if (blk_done) begin
              bp_q      <= 8'd0;
              n_q       <= nblk;
              row_end_q <= row_end;
              done_q    <= done_next;
              e_q       <= 8'd0;
              rd_cnt_q  <= 3'd0;
              state_q   <= S_HDR;
            end else begin
              bp_q <= bp_eff + 8'd1;
            end
          end
        end
        S_HDR: begin
          if (rd_cnt_q != 3'd0) begin
            hdr_q[2'(rd_cnt_q - 3'd1)] <= rdata;
          end
          if (rd_cnt_q == 3'd4) begin
            rd_cnt_q <= 3'd0;
            state_q  <= S_RD;
          end else begin
            rd_cnt_q <= rd_cnt_q + 3'd1;
          end
        end
        S_RD: begin
          if (rd_cnt_q != 3'd0) begin
            byte_q[rd_cnt_q - 3'd1] <= rdata;
          end
          if (rd_cnt_q == 3'd5) begin
            rd_cnt_q <= 3'd0;
            state_q  <= S_MUL1;
          end else begin
            rd_cnt_q <= rd_cnt_q + 3'd1;
          end
        end
        S_MUL1: begin
          f_mag_q  <= prod[17] ? 13'(-prod) : 13'(prod);
          f_sign_q <= a_s[8] ^ b_s[8];
          zero_q   <= (a_s == 9'sd0) || (b_s == 9'sd0);
          m_q      <= m6;
          state_q  <= S_MUL2;
        end
        S_MUL2: begin
          t1_q    <= f_mag_q * d_m;
          t2_q    <= m_q * dm_m;
          state_q <= S_ALN;
        end
        S_ALN: begin
          mag_q   <= amag;
          sgn_q   <= rsgn;
          emin_q  <= emin;
          sh_q    <= 6'd0;
          nan_q   <= nan_n;
          inf_q   <= inf_n;
          isg_q   <= isg_n;
          state_q <= S_NRM;
        end
        S_NRM: begin
          if (mag_q[W-1] || (mag_q == '0)) begin
            state_q <= S_RND;
          end else if (mag_q[W-1:W-8] == 8'd0) begin
            mag_q <= mag_q << 8;
            sh_q  <= sh_q + 6'd8;
          end else begin
            mag_q <= mag_q << 1;
            sh_q  <= sh_q + 6'd1;
          end
        end
        S_RND: begin
          val_q[e_q[1:0]] <= bits;
          if (e_q[1:0] == 2'd0) begin
            for (int k = 1; k < qbd_pkg::LANES; k++) begin
              val_q[k] <= 32'd0;
            end
          end
          if ((e_q[1:0] == 2'd3) || last_el) begin
            res_valid_q <= 1'b1;
            cnt_q       <= {1'b0, e_q[1:0]} + 3'd1;
            blast_q     <= last_el;
            rlast_q     <= last_el & row_end_q;
          end
          if (last_el) begin
            state_q <= S_IDLE;
          end else begin
            e_q     <= e_q + 8'd1;
            state_q <= S_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign value0_o       = val_q[0];
  assign value1_o       = val_q[1];
  assign value2_o       = val_q[2];
  assign value3_o       = val_q[3];
  assign valid_count_o  = cnt_q;
  assign block_last_o   = blast_q;
  assign row_last_o     = rlast_q;

endmodule
`default_nettype wire
